FILE: sv/lctm_pkg.sv
// Shared types, codes and constants of the load cell thrust monitor.
`default_nettype none

package lctm_pkg;

  typedef enum logic [1:0] {
    OP_ADC  = 2'd0,
    OP_REF  = 2'd1,
    OP_TICK = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    REG_MODE    = 3'd0,
    REG_CHAN    = 3'd1,
    REG_TARE    = 3'd2,
    REG_SCALE   = 3'd3,
    REG_ALPHA   = 3'd4,
    REG_TIMEOUT = 3'd5,
    REG_THRESH  = 3'd6
  } reg_idx_t;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic               RST_MODE    = 1'b0;
  localparam logic [7:0]         RST_CHAN    = 8'd0;
  localparam logic signed [23:0] RST_TARE    = 24'sd0;
  localparam logic signed [31:0] RST_SCALE   = 32'sd16777216;
  localparam logic [16:0]        RST_ALPHA   = 17'd16384;
  localparam logic [15:0]        RST_TIMEOUT = 16'd200;
  localparam logic [31:0]        RST_THRESH  = 32'd655360;

  localparam logic               MODE_ADC = 1'b0;

  localparam logic [16:0]        ALPHA_MIN   = 17'd655;
  localparam logic [16:0]        ALPHA_ONE   = 17'd65536;
  localparam logic [15:0]        TIMEOUT_MIN = 16'd10;
  localparam logic signed [31:0] SCALE_LO    = -32'sd17;
  localparam logic signed [31:0] SCALE_HI    = 32'sd17;
  localparam logic signed [24:0] REF_RAW_MUL = 25'sd100;
  localparam logic [23:0]        RAW_MAX     = 24'h7FFFFF;
  localparam logic [15:0]        HALF_Q16    = 16'h8000;
  localparam logic [31:0]        THRUST_MAX  = 32'hFFFFFFFF;

  localparam int F_NO_CHAN   = 0;
  localparam int F_BAD_SCALE = 1;
  localparam int F_NO_REF    = 2;
  localparam int F_STALE     = 3;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = QPTR_W + 1;

  typedef struct packed {
    logic               mode;
    logic [7:0]         chan;
    logic signed [23:0] tare;
    logic signed [31:0] scale;
    logic [16:0]        alpha;
    logic [15:0]        timeout;
    logic [31:0]        thresh;
  } cfg_t;

  // Snapshot of front state taken when a tick is accepted.
  typedef struct packed {
    logic               mode;
    logic               found;
    logic signed [23:0] raw;
    logic [47:0]        stamp;
    logic [31:0]        ref_thrust;
    logic               ref_present;
    logic [47:0]        now;
  } job_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_MEAS,
    ST_FILT_A,
    ST_FILT_B,
    ST_SUM,
    ST_OUT
  } back_state_t;

  typedef struct packed {
    logic pop;
    logic ld_meas;
    logic ld_stale;
    logic ld_acc;
    logic ld_filt;
    logic ld_out;
  } back_ctl_t;

endpackage

`default_nettype wire

FILE: sv/lctm_ifs.sv
// Handshake interfaces of the request, result and configuration channels.
`default_nettype none

interface lctm_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic        report_start;
  logic [7:0]  slot_channel;
  logic signed [23:0] slot_raw;
  logic [47:0] slot_time_us;
  logic [31:0] ref_thrust;
  logic        ref_loaded;
  logic [47:0] now_us;

  modport source (
    output valid, op, report_start, slot_channel, slot_raw, slot_time_us,
           ref_thrust, ref_loaded, now_us,
    input  ready
  );
  modport sink (
    input  valid, op, report_start, slot_channel, slot_raw, slot_time_us,
           ref_thrust, ref_loaded, now_us,
    output ready
  );
endinterface

interface lctm_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] measured_thrust;
  logic [31:0] filtered_thrust;
  logic [31:0] expected_thrust;
  logic signed [23:0] load_counts;
  logic [47:0] sample_time_us;
  logic [3:0]  fault_bits;
  logic        data_valid;
  logic        ignition_flag;

  modport source (
    output valid, measured_thrust, filtered_thrust, expected_thrust, load_counts,
           sample_time_us, fault_bits, data_valid, ignition_flag,
    input  ready
  );
  modport sink (
    input  valid, measured_thrust, filtered_thrust, expected_thrust, load_counts,
           sample_time_us, fault_bits, data_valid, ignition_flag,
    output ready
  );
endinterface

interface lctm_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: sv/lctm_front.sv
// Front end: takes every beat, tracks report slots and the reference, snapshots ticks.
`default_nettype none

module lctm_front
  import lctm_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  lctm_req_if.sink   req,
  input  wire cfg_t  cfg,
  input  wire logic  q_full,
  output logic       push,
  output job_t       job
);

  logic               pending_found;
  logic               report_matched;
  logic signed [23:0] pending_raw;
  logic [47:0]        pending_time;
  logic [31:0]        reference_thrust;
  logic               reference_present;

  logic accept;
  logic matched_eff;
  logic slot_hit;

  assign req.ready = !q_full && !rst;
  assign accept    = req.valid && req.ready;

  // A start mark opens a fresh report before the channel test.
  assign matched_eff = req.report_start ? 1'b0 : report_matched;
  assign slot_hit    = (req.slot_channel == cfg.chan) && !matched_eff;

  assign push = accept && (req.op == OP_TICK);

  always_comb begin
    job.mode        = cfg.mode;
    job.found       = pending_found;
    job.raw         = pending_raw;
    job.stamp       = pending_time;
    job.ref_thrust  = reference_thrust;
    job.ref_present = reference_present;
    job.now         = req.now_us;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_found     <= 1'b0;
      report_matched    <= 1'b0;
      reference_thrust  <= 32'd0;
      reference_present <= 1'b0;
    end else if (accept) begin
      case (req.op)
        OP_ADC: begin
          report_matched <= matched_eff || slot_hit;
          if (slot_hit) begin
            pending_found <= 1'b1;
          end else if (req.report_start) begin
            pending_found <= 1'b0;
          end
        end
        OP_REF: begin
          reference_thrust  <= req.ref_thrust;
          reference_present <= req.ref_loaded;
        end
        OP_TICK: begin
          // consume the latched sample; in reference mode it stays pending
          if (cfg.mode == MODE_ADC) begin
            pending_found <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (req.op == OP_ADC) && slot_hit) begin
      pending_raw  <= req.slot_raw;
      pending_time <= req.slot_time_us;
    end
  end

endmodule

`default_nettype wire

FILE: sv/lctm_queue.sv
// Short tick queue between the front end and the back end.
`default_nettype none

module lctm_queue
  import lctm_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire job_t wdata,
  input  wire logic pop,
  output job_t      rdata,
  output logic      full,
  output logic      empty
);

  job_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [QCNT_W-1:0] count;

  assign full  = (count == QCNT_W'(QDEPTH));
  assign empty = (count == '0);
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == QPTR_W'(QDEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (pop) begin
        rptr <= (rptr == QPTR_W'(QDEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= wdata;
    end
  end

endmodule

`default_nettype wire

FILE: sv/lctm_back.sv
// Back end: runs one tick through a shared multiplier and drives the result register.
`default_nettype none

module lctm_back
  import lctm_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire cfg_t cfg,
  input  wire job_t q_data,
  input  wire logic q_empty,
  output logic      q_pop,
  lctm_rsp_if.source rsp
);

  back_state_t state, state_next;
  back_ctl_t   ctl;

  job_t               job;
  logic signed [57:0] prod;
  logic [48:0]        acc;
  logic [3:0]         faults;

  logic [31:0]        measured_value;
  logic [31:0]        filtered_value;
  logic signed [23:0] last_raw;
  logic [47:0]        last_sample_time;

  logic               out_valid;
  logic               rsp_free;

  logic signed [32:0] mul_a;
  logic signed [24:0] mul_b;
  logic [16:0]        alpha_c;
  logic [15:0]        tmo_c;
  logic [25:0]        tmo_us;
  logic [47:0]        elapsed;
  logic               stale;
  logic               bad_scale;
  logic signed [24:0] diff;

  logic [22:0]        ref_q;
  logic [15:0]        ref_r;
  logic               ref_up;
  logic [23:0]        ref_q1;
  logic [23:0]        ref_raw;

  logic signed [57:0] prod_rnd;
  logic [49:0]        meas_full;
  logic [31:0]        meas_adc;

  logic [49:0]        filt_sum;

  assign rsp_free = !out_valid || rsp.ready;
  assign q_pop    = ctl.pop;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (!q_empty) state_next = ST_MUL;
      ST_MUL:    state_next = ST_MEAS;
      ST_MEAS:   state_next = ST_FILT_A;
      ST_FILT_A: state_next = ST_FILT_B;
      ST_FILT_B: state_next = ST_SUM;
      ST_SUM:    state_next = ST_OUT;
      ST_OUT:    if (rsp_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    ctl = '0;
    case (state)
      ST_IDLE:   ctl.pop      = !q_empty;
      ST_MUL:    ;
      ST_MEAS:   ctl.ld_meas  = 1'b1;
      ST_FILT_A: ctl.ld_stale = 1'b1;
      ST_FILT_B: ctl.ld_acc   = 1'b1;
      ST_SUM:    ctl.ld_filt  = 1'b1;
      ST_OUT:    ctl.ld_out   = rsp_free;
      default:   ctl = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // register clamps
  always_comb begin
    if (cfg.alpha < ALPHA_MIN) begin
      alpha_c = ALPHA_MIN;
    end else if (cfg.alpha > ALPHA_ONE) begin
      alpha_c = ALPHA_ONE;
    end else begin
      alpha_c = cfg.alpha;
    end
    tmo_c = (cfg.timeout < TIMEOUT_MIN) ? TIMEOUT_MIN : cfg.timeout;
  end

  // milliseconds to microseconds: x*1000 = x*1024 - x*16 - x*8
  assign tmo_us  = ({10'd0, tmo_c} << 10) - ({10'd0, tmo_c} << 4) - ({10'd0, tmo_c} << 3);
  assign elapsed = job.now - last_sample_time;
  assign stale   = (last_sample_time == 48'd0) || (elapsed > {22'd0, tmo_us});

  assign bad_scale = (cfg.scale > SCALE_LO) && (cfg.scale < SCALE_HI);
  assign diff      = 25'(job.raw) - 25'(cfg.tare);

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      ST_MUL: begin
        if (job.mode == MODE_ADC) begin
          mul_a = 33'(cfg.scale);
          mul_b = diff;
        end else begin
          mul_a = {1'b0, job.ref_thrust};
          mul_b = REF_RAW_MUL;
        end
      end
      ST_FILT_A: begin
        mul_a = {1'b0, measured_value};
        mul_b = {8'd0, alpha_c};
      end
      ST_FILT_B: begin
        mul_a = {1'b0, filtered_value};
        mul_b = {8'd0, ALPHA_ONE - alpha_c};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // reference thrust times 100 in Q16.16, round half to even
  assign ref_q   = prod[38:16];
  assign ref_r   = prod[15:0];
  assign ref_up  = (ref_r > HALF_Q16) || ((ref_r == HALF_Q16) && ref_q[0]);
  assign ref_q1  = {1'b0, ref_q} + {23'd0, ref_up};
  assign ref_raw = (ref_q1 > RAW_MAX) ? RAW_MAX : ref_q1;

  // ADC thrust: drop 8 fraction bits with round half up, clamp at zero and full scale
  assign prod_rnd  = prod + 58'sd128;
  assign meas_full = prod_rnd[57:8];
  always_comb begin
    if (prod[57] || (prod == '0)) begin
      meas_adc = 32'd0;
    end else if (|meas_full[49:32]) begin
      meas_adc = THRUST_MAX;
    end else begin
      meas_adc = meas_full[31:0];
    end
  end

  assign filt_sum = {1'b0, acc} + {1'b0, prod[48:0]} + 50'd32768;

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    if (ctl.pop) begin
      job <= q_data;
    end
    if (ctl.ld_meas) begin
      faults[F_NO_CHAN]   <= (job.mode == MODE_ADC) && !job.found;
      faults[F_BAD_SCALE] <= (job.mode == MODE_ADC) && bad_scale;
      faults[F_NO_REF]    <= !job.ref_present;
    end
    if (ctl.ld_stale) begin
      faults[F_STALE] <= stale;
    end
    if (ctl.ld_acc) begin
      acc <= prod[48:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      measured_value   <= 32'd0;
      filtered_value   <= 32'd0;
      last_raw         <= 24'sd0;
      last_sample_time <= 48'd0;
    end else begin
      if (ctl.ld_meas) begin
        if (job.mode != MODE_ADC) begin
          measured_value   <= job.ref_thrust;
          last_sample_time <= job.now;
          last_raw         <= ref_raw;
        end else if (job.found) begin
          measured_value   <= meas_adc;
          last_sample_time <= job.stamp;
          last_raw         <= job.raw;
        end
      end
      if (ctl.ld_filt) begin
        filtered_value <= filt_sum[47:16];
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.ld_out) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld_out) begin
      rsp.measured_thrust <= measured_value;
      rsp.filtered_thrust <= filtered_value;
      rsp.expected_thrust <= job.ref_thrust;
      rsp.load_counts     <= last_raw;
      rsp.sample_time_us  <= last_sample_time;
      rsp.fault_bits      <= faults;
      rsp.data_valid      <= (faults == 4'd0);
      rsp.ignition_flag   <= (filtered_value >= cfg.thresh);
    end
  end

  assign rsp.valid = out_valid;

endmodule

`default_nettype wire

FILE: sv/load_cell_thrust_monitor.sv
// Top level of the load cell thrust monitor: configuration registers and the two halves.
`default_nettype none

// ADC slots and reference updates are taken one a cycle and settle in the
// front end in that same cycle. A tick is snapshotted into a two-entry queue
// and worked off by the back end through the states MUL, MEAS, FILT_A, FILT_B,
// SUM and OUT, OUT waiting on the result channel; the back end's single shared
// multiplier is used three times per tick. With the queue full, new beats of
// any kind stall until the back end pops. The result register lets the next
// tick start while the previous result still waits. Configuration is taken every
// cycle out of reset and should only be written while no tick is in flight.
module load_cell_thrust_monitor
  import lctm_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  lctm_req_if.sink   req,
  lctm_rsp_if.source rsp,
  lctm_cfg_if.sink   cfg
);

  cfg_t cfg_regs;
  job_t push_job;
  job_t q_data;
  logic push;
  logic q_pop;
  logic q_full;
  logic q_empty;

  assign cfg.ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.mode    <= RST_MODE;
      cfg_regs.chan    <= RST_CHAN;
      cfg_regs.tare    <= RST_TARE;
      cfg_regs.scale   <= RST_SCALE;
      cfg_regs.alpha   <= RST_ALPHA;
      cfg_regs.timeout <= RST_TIMEOUT;
      cfg_regs.thresh  <= RST_THRESH;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_MODE:    cfg_regs.mode    <= cfg.data[0];
        REG_CHAN:    cfg_regs.chan    <= cfg.data[7:0];
        REG_TARE:    cfg_regs.tare    <= cfg.data[23:0];
        REG_SCALE:   cfg_regs.scale   <= cfg.data;
        REG_ALPHA:   cfg_regs.alpha   <= cfg.data[16:0];
        REG_TIMEOUT: cfg_regs.timeout <= cfg.data[15:0];
        REG_THRESH:  cfg_regs.thresh  <= cfg.data;
        default: begin
        end
      endcase
    end
  end

  lctm_front u_front (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .cfg    (cfg_regs),
    .q_full (q_full),
    .push   (push),
    .job    (push_job)
  );

  lctm_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (push_job),
    .pop   (q_pop),
    .rdata (q_data),
    .full  (q_full),
    .empty (q_empty)
  );

  lctm_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg_regs),
    .q_data  (q_data),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .rsp     (rsp)
  );

endmodule

`default_nettype wire
